// File: design/apss_pkg.sv
// Shared types and constants for the attractor particle step and splat block.
// No dependencies; imported by apss_div, apss_splat and the top level.
package apss_pkg;

  localparam int FRAC    = 16;
  localparam int NUM_W   = 48;
  localparam int DEN_W   = 50;
  localparam int QUO_W   = 48;
  localparam int DIV_LAT = QUO_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int EXT_W      = 13;
  localparam int PIX_W      = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULL_TOUCHED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULL_IDLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOFTENING    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE       = 3'd6;

  localparam logic [3:0] ITEM_GAP = 4'd9;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } state_t;

endpackage

// File: design/apss_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on apss_pkg for widths and fraction bits.
module apss_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [apss_pkg::NUM_W-1:0] in_num,
  input  logic [apss_pkg::DEN_W-1:0] in_den,
  output logic                       out_valid,
  output logic [apss_pkg::QUO_W-1:0] out_quo
);
  import apss_pkg::*;

  localparam int REM_W = DEN_W + 1;
  localparam int HI_W  = NUM_W + FRAC - QUO_W;

  logic             valid_r [QUO_W+1];
  logic [DEN_W-1:0] rem_r   [QUO_W+1];
  logic [QUO_W-1:0] rest_r  [QUO_W+1];
  logic [QUO_W-1:0] quo_r   [QUO_W+1];
  logic [DEN_W-1:0] den_r   [QUO_W+1];

  logic [REM_W-1:0] trial   [QUO_W];
  logic [REM_W-1:0] diff    [QUO_W];
  logic             ge      [QUO_W];
  logic [DEN_W-1:0] rem_nxt [QUO_W];

  always_comb begin
    for (int s = 0; s < QUO_W; s++) begin
      trial[s]   = {rem_r[s], rest_r[s][QUO_W-1]};
      diff[s]    = trial[s] - {1'b0, den_r[s]};
      ge[s]      = trial[s] >= {1'b0, den_r[s]};
      rem_nxt[s] = ge[s] ? diff[s][DEN_W-1:0] : trial[s][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= QUO_W; s++) valid_r[s] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
      for (int s = 0; s < QUO_W; s++) valid_r[s+1] <= valid_r[s];
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= DEN_W'(in_num[NUM_W-1 -: HI_W]);
    rest_r[0] <= {in_num[NUM_W-HI_W-1:0], {FRAC{1'b0}}};
    quo_r[0]  <= '0;
    den_r[0]  <= in_den;
    for (int s = 0; s < QUO_W; s++) begin
      rem_r[s+1]  <= rem_nxt[s];
      rest_r[s+1] <= {rest_r[s][QUO_W-2:0], 1'b0};
      quo_r[s+1]  <= {quo_r[s][QUO_W-2:0], ge[s]};
      den_r[s+1]  <= den_r[s];
    end
  end

  assign out_valid = valid_r[QUO_W];
  assign out_quo   = quo_r[QUO_W];

endmodule

// File: design/apss_splat.sv
// 3x3 splat sequencer: walks the neighborhood of one particle and emits pixel writes.
// Depends on apss_pkg for state_t and widths.
module apss_splat (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  apss_pkg::state_t           in_state,
  input  logic [apss_pkg::EXT_W-1:0] frame_w,
  input  logic [apss_pkg::EXT_W-1:0] frame_h,
  output logic                       out_valid,
  output logic signed [31:0]         out_next_pos_x,
  output logic signed [31:0]         out_next_pos_y,
  output logic signed [31:0]         out_next_vel_x,
  output logic signed [31:0]         out_next_vel_y,
  output logic [apss_pkg::PIX_W-1:0] out_pixel_col,
  output logic [apss_pkg::PIX_W-1:0] out_pixel_row,
  output logic [31:0]                out_pixel_color,
  output logic                       out_last_write
);
  import apss_pkg::*;

  state_t           st_r;
  logic             act_r;
  logic [1:0]       row_r;
  logic [1:0]       col_r;

  logic             out_valid_r;
  state_t           out_st_r;
  logic [PIX_W-1:0] col_out_r;
  logic [PIX_W-1:0] row_out_r;
  logic [31:0]      color_r;
  logic             last_r;

  logic [EXT_W-1:0] cx;
  logic [EXT_W-1:0] cy;
  logic [2:0]       cv;
  logic [2:0]       rv;
  logic [8:0]       mask;
  logic [3:0]       k;
  logic             emit;
  logic             last;
  logic [EXT_W:0]   xx;
  logic [EXT_W:0]   yy;
  logic [31:0]      core;
  logic [31:0]      halo;

  always_comb begin
    cx = st_r.pos_x[FRAC+EXT_W-1:FRAC];
    cy = st_r.pos_y[FRAC+EXT_W-1:FRAC];
    cv[0] = cx != '0;
    cv[1] = 1'b1;
    cv[2] = ((EXT_W+1)'(cx) + 1'b1) < (EXT_W+1)'(frame_w);
    rv[0] = cy != '0;
    rv[1] = 1'b1;
    rv[2] = ((EXT_W+1)'(cy) + 1'b1) < (EXT_W+1)'(frame_h);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) mask[r*3+c] = rv[r] & cv[c];
    end
    k    = {1'b0, row_r, 1'b0} + {2'b0, row_r} + {2'b0, col_r};
    emit = act_r & mask[k];
    last = (mask >> (k + 4'd1)) == 9'd0;
    xx   = (EXT_W+1)'(cx) + (EXT_W+1)'(col_r) - 1'b1;
    yy   = (EXT_W+1)'(cy) + (EXT_W+1)'(row_r) - 1'b1;
    core = {8'hFF, st_r.red, st_r.green, st_r.blue};
    halo = {8'hFF, 1'b0, st_r.red[7:1], 1'b0, st_r.green[7:1], 1'b0, st_r.blue[7:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
      if (in_valid) begin
        act_r <= 1'b1;
        row_r <= '0;
        col_r <= '0;
      end else if (act_r) begin
        if (col_r == 2'd2) begin
          col_r <= '0;
          if (row_r == 2'd2) begin
            act_r <= 1'b0;
            row_r <= '0;
          end else begin
            row_r <= row_r + 2'd1;
          end
        end else begin
          col_r <= col_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) st_r <= in_state;
    out_st_r  <= st_r;
    col_out_r <= xx[PIX_W-1:0];
    row_out_r <= yy[PIX_W-1:0];
    color_r   <= (row_r == 2'd1 && col_r == 2'd1) ? core : halo;
    last_r    <= last;
  end

  assign out_valid       = out_valid_r;
  assign out_next_pos_x  = out_st_r.pos_x;
  assign out_next_pos_y  = out_st_r.pos_y;
  assign out_next_vel_x  = out_st_r.vel_x;
  assign out_next_vel_y  = out_st_r.vel_y;
  assign out_pixel_col   = col_out_r;
  assign out_pixel_row   = row_out_r;
  assign out_pixel_color = color_r;
  assign out_last_write  = last_r;

endmodule

// File: design/attractor_particle_step_splat.sv
// Top level of the attractor particle step with 3x3 splat.
// Depends on apss_pkg, apss_div and apss_splat.
//
// Usage: drive a particle on the in_ ports and pulse start while busy is low;
// the transaction is taken at that clock edge. busy then stays high while the
// item gap counter runs down, and a new particle is taken only once it is low.
// Each particle gives 1 to 9 pixel-write transactions, each shown for exactly
// one cycle with out_valid high; out_last_write marks the final one, and all
// carry the updated position and velocity. The receiver cannot stall.
// Writes follow the neighborhood in row-major order from the top-left neighbor;
// a neighbor out of frame is skipped but still takes its step of the walk, so
// a particle's writes can have gaps between them; one write per cycle at most.
// The latency is set by the 49-register quotient pipeline (input register plus
// one quotient bit per stage), nine arithmetic stages and two splat stages.
// Configuration: cfg_we with cfg_index and cfg_data writes one register at the
// clock edge; write only while no particle is in flight.
// Reset (synchronous, rst_n low) empties the pipeline and loads the default
// register values.
module attractor_particle_step_splat (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [31:0]                  in_pos_x,
  input  logic signed [31:0]                  in_pos_y,
  input  logic signed [31:0]                  in_vel_x,
  input  logic signed [31:0]                  in_vel_y,
  input  logic [7:0]                          in_red,
  input  logic [7:0]                          in_green,
  input  logic [7:0]                          in_blue,
  input  logic [11:0]                         in_touch_col,
  input  logic [11:0]                         in_touch_row,
  input  logic                                in_touch_active,
  input  logic                                cfg_we,
  input  logic [apss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apss_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  output logic signed [31:0]                  out_next_pos_x,
  output logic signed [31:0]                  out_next_pos_y,
  output logic signed [31:0]                  out_next_vel_x,
  output logic signed [31:0]                  out_next_vel_y,
  output logic [apss_pkg::PIX_W-1:0]          out_pixel_col,
  output logic [apss_pkg::PIX_W-1:0]          out_pixel_row,
  output logic [31:0]                         out_pixel_color,
  output logic                                out_last_write
);
  import apss_pkg::*;

  typedef struct packed {
    logic [1:0][31:0] pos;
    logic [1:0][31:0] vel;
    logic [23:0]      color;
    logic [1:0]       neg;
  } pl_t;

  // configuration
  logic [EXT_W-1:0] frame_w_r;
  logic [EXT_W-1:0] frame_h_r;
  logic [15:0]      pull_t_r;
  logic [15:0]      pull_i_r;
  logic [15:0]      soft_r;
  logic [15:0]      damp_r;
  logic [15:0]      bounce_r;

  logic [EXT_W-1:0] ext   [2];
  logic [15:0]      soft_eff;

  logic [3:0] gap_r;
  logic       accept;

  // stage 0
  logic             s0_v_r;
  logic [31:0]      s0_pos_r [2];
  logic [31:0]      s0_vel_r [2];
  logic [11:0]      s0_tch_r [2];
  logic [15:0]      s0_pull_r;
  logic [23:0]      s0_col_r;
  // stage 1
  logic [32:0]      s1_d      [2];
  logic             s1_v_r;
  logic [31:0]      s1_mag_r [2];
  logic             s1_neg_r [2];
  logic [31:0]      s1_pos_r [2];
  logic [31:0]      s1_vel_r [2];
  logic [15:0]      s1_pull_r;
  logic [23:0]      s1_col_r;
  // stage 2
  logic             s2_v_r;
  logic [63:0]      s2_sq_r  [2];
  logic [NUM_W-1:0] s2_num_r [2];
  pl_t              s2_pl_r;
  // stage 3
  logic             s3_v_r;
  logic [DEN_W-1:0] s3_den_r;
  logic [NUM_W-1:0] s3_num_r [2];
  pl_t              s3_pl_r;
  pl_t              s1_pl;
  // divider
  logic             dv_v   [2];
  logic [QUO_W-1:0] dv_q   [2];
  pl_t              pl_r   [DIV_LAT];
  // post stages
  logic [DEN_W-1:0] d1_sum [2];
  logic [DEN_W-1:0] d1_q   [2];
  logic             d1_v_r;
  logic [31:0]      d1_vel_r [2];
  logic [31:0]      d1_pos_r [2];
  logic [23:0]      d1_col_r;
  logic [31:0]      d2_mag   [2];
  logic             d2_v_r;
  logic [47:0]      d2_prod_r [2];
  logic             d2_neg_r  [2];
  logic [31:0]      d2_pos_r  [2];
  logic [23:0]      d2_col_r;
  logic             d3_v_r;
  logic [31:0]      d3_md_r  [2];
  logic [31:0]      d3_vel_r [2];
  logic             d3_neg_r [2];
  logic [31:0]      d3_pos_r [2];
  logic [23:0]      d3_col_r;
  logic [32:0]      d4_sum   [2];
  logic [47:0]      d4_bp    [2];
  logic             d4_v_r;
  logic [31:0]      d4_pos_r [2];
  logic [31:0]      d4_vel_r [2];
  logic             d4_neg_r [2];
  logic [31:0]      d4_mb_r  [2];
  logic [23:0]      d4_col_r;
  logic [31:0]      d5_pos   [2];
  logic [31:0]      d5_vel   [2];
  logic [31:0]      d5_refl  [2];
  logic             d5_v_r;
  state_t           d5_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= 13'd1024;
      frame_h_r <= 13'd600;
      pull_t_r  <= 16'd900;
      pull_i_r  <= 16'd260;
      soft_r    <= 16'd400;
      damp_r    <= 16'd64553;
      bounce_r  <= 16'd52429;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_w_r <= cfg_data[EXT_W-1:0];
        REG_FRAME_HEIGHT: frame_h_r <= cfg_data[EXT_W-1:0];
        REG_PULL_TOUCHED: pull_t_r  <= cfg_data;
        REG_PULL_IDLE:    pull_i_r  <= cfg_data;
        REG_SOFTENING:    soft_r    <= cfg_data;
        REG_DAMPING:      damp_r    <= cfg_data;
        REG_BOUNCE:       bounce_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ext[0]   = (frame_w_r == '0) ? EXT_W'(1) : frame_w_r;
  assign ext[1]   = (frame_h_r == '0) ? EXT_W'(1) : frame_h_r;
  assign soft_eff = (soft_r == '0) ? 16'd1 : soft_r;

  assign accept = start & ~busy;
  assign busy   = gap_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else if (accept) begin
      gap_r <= ITEM_GAP - 4'd1;
    end else if (gap_r != '0) begin
      gap_r <= gap_r - 4'd1;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
      d3_v_r <= 1'b0;
      d4_v_r <= 1'b0;
      d5_v_r <= 1'b0;
    end else begin
      s0_v_r <= accept;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      d1_v_r <= dv_v[0];
      d2_v_r <= d1_v_r;
      d3_v_r <= d2_v_r;
      d4_v_r <= d3_v_r;
      d5_v_r <= d4_v_r;
    end
  end

  // capture, offset, products, divisor
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      s1_d[a] = {{(33-12-FRAC){1'b0}}, s0_tch_r[a], {FRAC{1'b0}}}
              - {s0_pos_r[a][31], s0_pos_r[a]};
    end
    s1_pl.pos   = {s1_pos_r[1], s1_pos_r[0]};
    s1_pl.vel   = {s1_vel_r[1], s1_vel_r[0]};
    s1_pl.color = s1_col_r;
    s1_pl.neg   = {s1_neg_r[1], s1_neg_r[0]};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_pos_r[0] <= in_pos_x;
      s0_pos_r[1] <= in_pos_y;
      s0_vel_r[0] <= in_vel_x;
      s0_vel_r[1] <= in_vel_y;
      s0_tch_r[0] <= in_touch_col;
      s0_tch_r[1] <= in_touch_row;
      s0_pull_r   <= in_touch_active ? pull_t_r : pull_i_r;
      s0_col_r    <= {in_red, in_green, in_blue};
    end
    for (int a = 0; a < 2; a++) begin
      s1_mag_r[a] <= s1_d[a][32] ? (~s1_d[a][31:0] + 32'd1) : s1_d[a][31:0];
      s1_neg_r[a] <= s1_d[a][32];
      s1_pos_r[a] <= s0_pos_r[a];
      s1_vel_r[a] <= s0_vel_r[a];
      s2_sq_r[a]  <= 64'(s1_mag_r[a]) * 64'(s1_mag_r[a]);
      s2_num_r[a] <= NUM_W'(s1_mag_r[a]) * NUM_W'(s1_pull_r);
      s3_num_r[a] <= s2_num_r[a];
    end
    s1_pull_r <= s0_pull_r;
    s1_col_r  <= s0_col_r;
    s2_pl_r   <= s1_pl;
    s3_den_r  <= DEN_W'(s2_sq_r[0][63:FRAC]) + DEN_W'(s2_sq_r[1][63:FRAC])
               + DEN_W'({soft_eff, {FRAC{1'b0}}});
    s3_pl_r   <= s2_pl_r;
    pl_r[0]   <= s3_pl_r;
    for (int s = 1; s < DIV_LAT; s++) pl_r[s] <= pl_r[s-1];
  end

  apss_div u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .in_num    (s3_num_r[0]),
    .in_den    (s3_den_r),
    .out_valid (dv_v[0]),
    .out_quo   (dv_q[0])
  );

  apss_div u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .in_num    (s3_num_r[1]),
    .in_den    (s3_den_r),
    .out_valid (dv_v[1]),
    .out_quo   (dv_q[1])
  );

  // velocity update, damping, move, edges
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      d1_q[a]   = {2'b00, dv_q[a]};
      d1_sum[a] = (pl_r[DIV_LAT-1].neg[a] ? (~d1_q[a] + DEN_W'(1)) : d1_q[a])
                + {{(DEN_W-32){pl_r[DIV_LAT-1].vel[a][31]}}, pl_r[DIV_LAT-1].vel[a]};
      d2_mag[a] = d1_vel_r[a][31] ? (~d1_vel_r[a] + 32'd1) : d1_vel_r[a];
      d4_sum[a] = {d3_pos_r[a][31], d3_pos_r[a]} + {d3_vel_r[a][31], d3_vel_r[a]};
      d4_bp[a]  = 48'(d3_md_r[a]) * 48'(bounce_r);
      d5_refl[a] = d4_neg_r[a] ? d4_mb_r[a] : (~d4_mb_r[a] + 32'd1);
      d5_pos[a] = d4_pos_r[a];
      d5_vel[a] = d4_vel_r[a];
      if (d4_pos_r[a][31]) begin
        d5_pos[a] = '0;
        d5_vel[a] = d5_refl[a];
      end else if ($signed(d4_pos_r[a]) >= $signed({3'b000, ext[a], {FRAC{1'b0}}})) begin
        d5_pos[a] = {3'b000, ext[a] - EXT_W'(1), {FRAC{1'b0}}};
        d5_vel[a] = d5_refl[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      if (d1_sum[a][DEN_W-1:31] != '0 && d1_sum[a][DEN_W-1:31] != '1) begin
        d1_vel_r[a] <= d1_sum[a][DEN_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        d1_vel_r[a] <= d1_sum[a][31:0];
      end
      d1_pos_r[a]  <= pl_r[DIV_LAT-1].pos[a];
      d2_prod_r[a] <= 48'(d2_mag[a]) * 48'(damp_r);
      d2_neg_r[a]  <= d1_vel_r[a][31];
      d2_pos_r[a]  <= d1_pos_r[a];
      d3_md_r[a]   <= d2_prod_r[a][47:16];
      d3_vel_r[a]  <= d2_neg_r[a] ? (~d2_prod_r[a][47:16] + 32'd1) : d2_prod_r[a][47:16];
      d3_neg_r[a]  <= d2_neg_r[a];
      d3_pos_r[a]  <= d2_pos_r[a];
      if (d4_sum[a][32] != d4_sum[a][31]) begin
        d4_pos_r[a] <= d4_sum[a][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        d4_pos_r[a] <= d4_sum[a][31:0];
      end
      d4_vel_r[a] <= d3_vel_r[a];
      d4_neg_r[a] <= d3_neg_r[a];
      d4_mb_r[a]  <= d4_bp[a][47:16];
    end
    d1_col_r <= pl_r[DIV_LAT-1].color;
    d2_col_r <= d1_col_r;
    d3_col_r <= d2_col_r;
    d4_col_r <= d3_col_r;
    d5_st_r.pos_x <= d5_pos[0];
    d5_st_r.pos_y <= d5_pos[1];
    d5_st_r.vel_x <= d5_vel[0];
    d5_st_r.vel_y <= d5_vel[1];
    d5_st_r.red   <= d4_col_r[23:16];
    d5_st_r.green <= d4_col_r[15:8];
    d5_st_r.blue  <= d4_col_r[7:0];
  end

  apss_splat u_splat (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (d5_v_r),
    .in_state        (d5_st_r),
    .frame_w         (ext[0]),
    .frame_h         (ext[1]),
    .out_valid       (out_valid),
    .out_next_pos_x  (out_next_pos_x),
    .out_next_pos_y  (out_next_pos_y),
    .out_next_vel_x  (out_next_vel_x),
    .out_next_vel_y  (out_next_vel_y),
    .out_pixel_col   (out_pixel_col),
    .out_pixel_row   (out_pixel_row),
    .out_pixel_color (out_pixel_color),
    .out_last_write  (out_last_write)
  );

endmodule

// File: tb/sv/tb.sv
// Testbench for attractor_particle_step_splat: drives particles through the command port
// and checks every pixel write against a built-in fixed-point prediction.
// Depends on apss_pkg and the attractor_particle_step_splat RTL.
`timescale 1ns / 100ps

module tb;
  import apss_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 3000;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic [7:0]         red, green, blue;
    logic [11:0]        touch_col, touch_row;
    logic               touch_active;
  } particle_t;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic [11:0]        col, row;
    logic [31:0]        color;
    logic               last;
  } pixel_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_vel_x = '0, in_vel_y = '0;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic [11:0] in_touch_col = '0, in_touch_row = '0;
  logic in_touch_active = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic signed [31:0] out_next_pos_x, out_next_pos_y, out_next_vel_x, out_next_vel_y;
  logic [PIX_W-1:0] out_pixel_col, out_pixel_row;
  logic [31:0] out_pixel_color;
  logic out_last_write;

  logic [12:0] frame_w, frame_h;
  logic [15:0] pull_touched, pull_idle, soft_term, damp_k, bounce_k;

  particle_t    particle_queue[$];
  pixel_write_t pending_writes[$];
  int  idle_pct = 0;
  bit  took = 1'b0;
  int  fails = 0;
  int  stall_cycles = 0;

  attractor_particle_step_splat uut (.*);

  always #6 clk = ~clk;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scale_q16(longint v, longint unsigned k);
    longint unsigned m;
    m = ((v < 0 ? longint'(-v) : v) * k) >> 16;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint pull_delta(longint d, longint unsigned pull,
                                        longint unsigned den);
    logic [127:0] num;
    longint unsigned q;
    num = 128'((d < 0 ? longint'(-d) : d)) * 128'(pull);
    q = 64'((num << 16) / 128'(den));
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void advance_axis(inout longint p, inout longint v, input longint d,
                                       input longint unsigned pull, input longint unsigned den,
                                       input longint ext);
    longint edge_pos;
    edge_pos = ext << 16;
    v = sat32(v + pull_delta(d, pull, den));
    v = scale_q16(v, longint'(damp_k));
    p = sat32(p + v);
    if (p < 0) begin
      p = 0;
      v = -scale_q16(v, longint'(bounce_k));
    end
    if (p >= edge_pos) begin
      p = (ext - 1) << 16;
      v = -scale_q16(v, longint'(bounce_k));
    end
  endfunction

  function automatic void predict_splat(particle_t it);
    longint px, py, vx, vy, dx, dy, w, h, cx, cy, xx, yy;
    longint unsigned mx, my, den, sft, pull;
    logic [31:0] core, halo;
    pixel_write_t wr;
    px = it.pos_x; py = it.pos_y; vx = it.vel_x; vy = it.vel_y;
    w = frame_w == 0 ? 64'sd1 : longint'(frame_w);
    h = frame_h == 0 ? 64'sd1 : longint'(frame_h);
    sft = soft_term == 0 ? 64'd1 : longint'(soft_term);
    pull = it.touch_active ? longint'(pull_touched) : longint'(pull_idle);
    dx = (longint'(it.touch_col) << 16) - px;
    dy = (longint'(it.touch_row) << 16) - py;
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    den = ((mx * mx) >> 16) + ((my * my) >> 16) + (sft << 16);
    advance_axis(px, vx, dx, pull, den, w);
    advance_axis(py, vy, dy, pull, den, h);
    core = {8'hFF, it.red, it.green, it.blue};
    halo = {8'hFF, 1'b0, it.red[7:1], 1'b0, it.green[7:1], 1'b0, it.blue[7:1]};
    cx = px >>> 16;
    cy = py >>> 16;
    for (int oy = -1; oy <= 1; oy++) begin
      yy = cy + oy;
      if (yy < 0 || yy >= h) continue;
      for (int ox = -1; ox <= 1; ox++) begin
        xx = cx + ox;
        if (xx < 0 || xx >= w) continue;
        wr.pos_x = px[31:0]; wr.pos_y = py[31:0];
        wr.vel_x = vx[31:0]; wr.vel_y = vy[31:0];
        wr.col = xx[11:0]; wr.row = yy[11:0];
        wr.color = (ox == 0 && oy == 0) ? core : halo;
        wr.last = 1'b0;
        pending_writes.push_back(wr);
      end
    end
    pending_writes[pending_writes.size()-1].last = 1'b1;
  endfunction

  // driver
  always @(negedge clk) begin
    particle_t it;
    if (rst_n) begin
      if (start && !took) begin
      end else if (particle_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        it = particle_queue.pop_front();
        in_pos_x <= it.pos_x; in_pos_y <= it.pos_y;
        in_vel_x <= it.vel_x; in_vel_y <= it.vel_y;
        in_red <= it.red; in_green <= it.green; in_blue <= it.blue;
        in_touch_col <= it.touch_col; in_touch_row <= it.touch_row;
        in_touch_active <= it.touch_active;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
      took = 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    particle_t it;
    pixel_write_t e;
    if (rst_n) begin
      stall_cycles++;
      if (start && !busy) begin
        it.pos_x = in_pos_x; it.pos_y = in_pos_y;
        it.vel_x = in_vel_x; it.vel_y = in_vel_y;
        it.red = in_red; it.green = in_green; it.blue = in_blue;
        it.touch_col = in_touch_col; it.touch_row = in_touch_row;
        it.touch_active = in_touch_active;
        predict_splat(it);
        took = 1'b1;
        stall_cycles = 0;
      end
      if (out_valid) begin
        stall_cycles = 0;
        if (pending_writes.size() == 0) begin
          $error("pixel write with no transaction expected");
          fails++;
        end else begin
          e = pending_writes.pop_front();
          if (out_next_pos_x !== e.pos_x) begin
            $error("next_pos_x exp %0d got %0d", e.pos_x, out_next_pos_x); fails++;
          end
          if (out_next_pos_y !== e.pos_y) begin
            $error("next_pos_y exp %0d got %0d", e.pos_y, out_next_pos_y); fails++;
          end
          if (out_next_vel_x !== e.vel_x) begin
            $error("next_vel_x exp %0d got %0d", e.vel_x, out_next_vel_x); fails++;
          end
          if (out_next_vel_y !== e.vel_y) begin
            $error("next_vel_y exp %0d got %0d", e.vel_y, out_next_vel_y); fails++;
          end
          if (out_pixel_col !== e.col) begin
            $error("pixel_col exp %0d got %0d", e.col, out_pixel_col); fails++;
          end
          if (out_pixel_row !== e.row) begin
            $error("pixel_row exp %0d got %0d", e.row, out_pixel_row); fails++;
          end
          if (out_pixel_color !== e.color) begin
            $error("pixel_color exp %h got %h", e.color, out_pixel_color); fails++;
          end
          if (out_last_write !== e.last) begin
            $error("last_write exp %0b got %0b", e.last, out_last_write); fails++;
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic add_particle(int px, int py, int vx, int vy, int r, int g, int b,
                              int tc, int tr, int ta);
    particle_t it;
    it.pos_x = px; it.pos_y = py; it.vel_x = vx; it.vel_y = vy;
    it.red = 8'(r); it.green = 8'(g); it.blue = 8'(b);
    it.touch_col = 12'(tc); it.touch_row = 12'(tr); it.touch_active = 1'(ta);
    particle_queue.push_back(it);
  endtask

  task automatic add_random(int n);
    int unsigned w, h;
    for (int i = 0; i < n; i++) begin
      w = frame_w == 0 ? 1 : frame_w;
      h = frame_h == 0 ? 1 : frame_h;
      if ($urandom_range(9) < 7)
        add_particle(int'($urandom_range(0, (w + 2) << 16)) - 65536,
                     int'($urandom_range(0, (h + 2) << 16)) - 65536,
                     int'($urandom_range(0, 16 << 16)) - (8 << 16),
                     int'($urandom_range(0, 16 << 16)) - (8 << 16),
                     $urandom, $urandom, $urandom,
                     $urandom_range(0, w > 4095 ? 4095 : w),
                     $urandom_range(0, h > 4095 ? 4095 : h), $urandom);
      else
        add_particle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_FRAME_WIDTH:  frame_w = val[12:0];
      REG_FRAME_HEIGHT: frame_h = val[12:0];
      REG_PULL_TOUCHED: pull_touched = val;
      REG_PULL_IDLE:    pull_idle = val;
      REG_SOFTENING:    soft_term = val;
      REG_DAMPING:      damp_k = val;
      REG_BOUNCE:       bounce_k = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (particle_queue.size() > 0 || start || pending_writes.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_regs(int w, int h, int pt, int pi, int s, int d, int b);
    write_reg(REG_FRAME_WIDTH, 16'(w));
    write_reg(REG_FRAME_HEIGHT, 16'(h));
    write_reg(REG_PULL_TOUCHED, 16'(pt));
    write_reg(REG_PULL_IDLE, 16'(pi));
    write_reg(REG_SOFTENING, 16'(s));
    write_reg(REG_DAMPING, 16'(d));
    write_reg(REG_BOUNCE, 16'(b));
  endtask

  initial begin
    frame_w = 1024; frame_h = 600; pull_touched = 900; pull_idle = 260;
    soft_term = 400; damp_k = 64553; bounce_k = 52429;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 0;
    add_particle(100 << 16, 100 << 16, 0, 0, 255, 255, 255, 512, 300, 1);
    add_particle(100 << 16, 100 << 16, 0, 0, 0, 0, 0, 512, 300, 0);
    add_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 255, 0, 255, 4095, 4095, 1);
    add_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 0, 255, 0, 0, 0, 0);
    add_particle(0, 0, 0, 0, 17, 34, 51, 0, 0, 1);
    add_particle(1023 << 16, 599 << 16, 0, 0, 200, 100, 50, 1023, 599, 1);
    add_particle(1023 << 16, 10 << 16, 40 << 16, 0, 1, 2, 3, 1023, 10, 0);
    add_particle(5 << 16, 599 << 16, 0, 40 << 16, 9, 9, 9, 5, 599, 0);
    add_particle(2 << 16, 2 << 16, -(40 << 16), -(40 << 16), 128, 127, 1, 0, 0, 1);
    add_particle(500 << 16, 300 << 16, 3 << 16, -(2 << 16), 77, 88, 99, 500, 300, 1);
    add_particle(-(50 << 16), 700 << 16, 0, 0, 255, 255, 255, 4095, 0, 1);
    add_particle(500 << 16, 300 << 16, 0, 0, 10, 20, 30, 0, 4095, 0);
    add_random(60);

    wait_drained();
    idle_pct = 60;
    load_regs(1, 1, 65535, 0, 0, 65535, 0);
    add_particle(0, 0, 0, 0, 255, 255, 255, 0, 0, 1);
    add_particle(5 << 16, 5 << 16, 0, 0, 1, 1, 1, 4095, 4095, 1);
    add_particle(0, 0, 0, 0, 1, 1, 1, 4095, 4095, 0);
    add_random(70);

    wait_drained();
    idle_pct = 0;
    load_regs(0, 8191, 0, 65535, 65535, 0, 65535);
    add_particle(0, 5000 << 16, 0, 0, 255, 0, 0, 0, 4095, 0);
    add_particle(0, 8190 << 16, 0, 0, 255, 0, 0, 0, 4095, 0);
    add_random(70);

    wait_drained();
    idle_pct = 12;
    load_regs(4096, 4096, 3000, 40, 1, 60000, 30000);
    add_particle(4095 << 16, 4095 << 16, 0, 0, 255, 255, 255, 4095, 4095, 1);
    add_random(80);

    wait_drained();
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: attractor_particle_step_splat.f
design/apss_pkg.sv
design/apss_div.sv
design/apss_splat.sv
design/attractor_particle_step_splat.sv
tb/sv/tb.sv
